@@ design/weighted_normal_projection_tensor_assert.svh @@
// assertion macros for the weighted normal projection tensor block
`ifndef WEIGHTED_NORMAL_PROJECTION_TENSOR_ASSERT_SVH
`define WEIGHTED_NORMAL_PROJECTION_TENSOR_ASSERT_SVH
// property that must hold at every clock edge outside reset
`define WNPT_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// property checked also during reset
`define WNPT_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ design/wnpt_pkg.sv @@
// package for the weighted normal projection tensor block
package wnpt_pkg;
   localparam int GRAD_W = 32;
   localparam int MAG_W  = 33;
   localparam int SUM_W  = 32;
   localparam int VAL_W  = 16;
   localparam int NUM_TERMS = 6;
   localparam int SCALED_W = 15;
   localparam int RECIP_BITS = 31;

   // which gradient axes form each tensor term, order xx xy xz yy yz zz
   function automatic logic [1:0] term_i(input logic [2:0] k);
      case (k)
         3'd0, 3'd1, 3'd2: term_i = 2'd0;
         3'd3, 3'd4:       term_i = 2'd1;
         default:          term_i = 2'd2;
      endcase
   endfunction

   function automatic logic [1:0] term_j(input logic [2:0] k);
      case (k)
         3'd0:       term_j = 2'd0;
         3'd1, 3'd3: term_j = 2'd1;
         default:    term_j = 2'd2;
      endcase
   endfunction
endpackage

@@ design/weighted_normal_projection_tensor.sv @@
// weighted normal projection tensor: sequencer with one shared restoring divider
// nonzero gradient: normalize, then per term setup, divide, multiply, accumulate, then emit
// zero gradient: normalize goes straight to emit; a new input is taken only back in idle
// each tensor term takes setup, 31 quotient bits, multiply and accumulate
// a last item is held off while an earlier result has not been transferred
// reset is synchronous, active high: sums, flag and handshakes clear at once
`include "weighted_normal_projection_tensor_assert.svh"
module weighted_normal_projection_tensor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [15:0] req_eta_value,
   input  logic signed [31:0] req_grad_x,
   input  logic signed [31:0] req_grad_y,
   input  logic signed [31:0] req_grad_z,
   input  logic        req_last_op,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_s_xx,
   output logic signed [31:0] rsp_s_xy,
   output logic signed [31:0] rsp_s_xz,
   output logic signed [31:0] rsp_s_yy,
   output logic signed [31:0] rsp_s_yz,
   output logic signed [31:0] rsp_s_zz,
   output logic        rsp_saturated
);
   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_NORM  = 3'd1;
   localparam logic [2:0] ST_SETUP = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_MUL   = 3'd4;
   localparam logic [2:0] ST_ACC   = 3'd5;
   localparam logic [2:0] ST_EMIT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [15:0] val_ff, val_in;
   logic last_ff, last_in;
   logic [2:0] neg_ff, neg_in;
   logic [32:0] mag_ff [3];
   logic [32:0] mag_in [3];
   logic [2:0] term_ff, term_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [30:0] quo_ff, quo_in;
   logic [30:0] num_ff, num_in;     // remaining dividend bits, shifted out msb first
   logic [32:0] rem_ff, rem_in;
   logic [31:0] q_ff, q_in;
   logic signed [31:0] sum_ff [6];
   logic signed [31:0] sum_in [6];
   logic ovf_ff, ovf_in;
   logic signed [48:0] prod_ff, prod_in;
   logic out_valid_ff, out_valid_in;
   logic [31:0] out_ff [6];
   logic [31:0] out_in [6];
   logic out_sat_ff, out_sat_in;

   logic [32:0] mag_raw [3];
   logic [32:0] mmax;
   logic [5:0] msb;
   logic [32:0] rem_try;
   logic [29:0] pij;
   logic [31:0] qsum;
   logic [61:0] dvd;
   logic signed [47:0] vmul;
   logic [48:0] pmag;
   logic [28:0] tmag;
   logic signed [33:0] acc;
   logic tneg;
   logic [1:0] ti, tj;

   assign mag_raw[0] = req_grad_x[31] ? 33'(-{1'b1, req_grad_x}) : {1'b0, req_grad_x};
   assign mag_raw[1] = req_grad_y[31] ? 33'(-{1'b1, req_grad_y}) : {1'b0, req_grad_y};
   assign mag_raw[2] = req_grad_z[31] ? 33'(-{1'b1, req_grad_z}) : {1'b0, req_grad_z};

   assign req_ready = (state_ff == ST_IDLE) && (!out_valid_ff || rsp_ready || !req_last_op);

   // bit position of the largest magnitude
   always_comb begin
      mmax = mag_ff[0] | mag_ff[1] | mag_ff[2];
      msb = '0;
      for (int b = 0; b < 33; b++) begin
         if (mmax[b]) msb = 6'(b);
      end
   end

   always_comb begin
      ti = wnpt_pkg::term_i(term_ff);
      tj = wnpt_pkg::term_j(term_ff);
      pij = 30'(mag_ff[ti][14:0] * mag_ff[tj][14:0]);
      qsum = 32'(mag_ff[0][14:0] * mag_ff[0][14:0])
           + 32'(mag_ff[1][14:0] * mag_ff[1][14:0])
           + 32'(mag_ff[2][14:0] * mag_ff[2][14:0]);
      // dividend p * 2^30 + q/2, rounds the quotient to nearest
      dvd = {2'b00, pij, 30'd0} + {31'd0, qsum[31:1]};
      tneg = neg_ff[ti] ^ neg_ff[tj];
      rem_try = {rem_ff[31:0], num_ff[30]};
      vmul = $signed(val_ff) * $signed({1'b0, quo_ff});
      pmag = prod_ff[48] ? 49'(-prod_ff) : prod_ff;
      tmag = 29'((pmag + 49'(1 << 20)) >> 21);
      acc = 34'(sum_ff[term_ff]) + (prod_ff[48] ? -34'(tmag) : 34'(tmag));
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      val_in = val_ff;
      last_in = last_ff;
      neg_in = neg_ff;
      mag_in = mag_ff;
      term_in = term_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      sum_in = sum_ff;
      ovf_in = ovf_ff;
      prod_in = prod_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in = out_ff;
      out_sat_in = out_sat_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               val_in = req_eta_value;
               last_in = req_last_op;
               neg_in = {req_grad_z[31], req_grad_y[31], req_grad_x[31]};
               mag_in = mag_raw;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            // scale so the largest magnitude lies in [2^14, 2^15)
            if (mmax == '0) begin
               state_in = ST_EMIT;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  mag_in[i] = (msb >= 6'd14) ? (mag_ff[i] >> (msb - 6'd14))
                                             : (mag_ff[i] << (6'd14 - msb));
               end
               term_in = '0;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // quotient fits in 31 bits, so the top 31 dividend bits start as remainder
            q_in = qsum;
            rem_in = {2'b00, dvd[61:31]};
            num_in = dvd[30:0];
            quo_in = '0;
            cnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle, 31 bits
            rem_in = rem_try >= {1'b0, q_ff} ? rem_try - {1'b0, q_ff} : rem_try;
            quo_in = {quo_ff[29:0], rem_try >= {1'b0, q_ff}};
            num_in = {num_ff[29:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd30) state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in = tneg ? -49'(vmul) : 49'(vmul);
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (acc > 34'sh7FFFFFFF) begin
               sum_in[term_ff] = 32'sh7FFFFFFF; ovf_in = 1'b1;
            end else if (acc < -34'sh80000000) begin
               sum_in[term_ff] = 32'sh80000000; ovf_in = 1'b1;
            end else begin
               sum_in[term_ff] = 32'(acc);
            end
            term_in = term_ff + 3'd1;
            state_in = (term_ff == 3'd5) ? ST_EMIT : ST_SETUP;
         end
         ST_EMIT: begin
            if (last_ff) begin
               out_valid_in = 1'b1;
               for (int k = 0; k < 6; k++) out_in[k] = sum_ff[k];
               out_sat_in = ovf_ff;
               for (int k = 0; k < 6; k++) sum_in[k] = '0;
               ovf_in = 1'b0;
            end
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         out_valid_ff <= 1'b0;
         ovf_ff <= 1'b0;
         for (int k = 0; k < 6; k++) sum_ff[k] <= '0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         ovf_ff <= ovf_in;
         sum_ff <= sum_in;
      end
      val_ff <= val_in; last_ff <= last_in; neg_ff <= neg_in; mag_ff <= mag_in;
      term_ff <= term_in; cnt_ff <= cnt_in; quo_ff <= quo_in; num_ff <= num_in;
      rem_ff <= rem_in; q_ff <= q_in; prod_ff <= prod_in;
      out_ff <= out_in; out_sat_ff <= out_sat_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_s_xx = out_ff[0];
   assign rsp_s_xy = out_ff[1];
   assign rsp_s_xz = out_ff[2];
   assign rsp_s_yy = out_ff[3];
   assign rsp_s_yz = out_ff[4];
   assign rsp_s_zz = out_ff[5];
   assign rsp_saturated = out_sat_ff;

   // checks
   `WNPT_ASSERT(a_emit_only_last, clock, reset, (state_ff == ST_EMIT && !last_ff) |=> !$rose(rsp_valid), "result without last mark")
   `WNPT_ASSERT(a_busy_not_ready, clock, reset, (state_ff != ST_IDLE) |-> !req_ready, "ready while busy")
   `WNPT_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_valid && state_ff == ST_IDLE), "reset did not clear")
endmodule
